/* design/clnw_pkg.sv */
// ----------------------------------------------------------------------------
// clnw_pkg
// Shared types, constants and the start-up nibble table of the character-LCD
// nibble writer.
// ----------------------------------------------------------------------------
`default_nettype none

package clnw_pkg;

  // Command codes carried on the input tuser
  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_WRITE  = 3'd1,
    CMD_SETPOS = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_INIT   = 3'd4
  } cmd_e;

  // Configuration register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_COLUMN_COUNT   = 3'd0,
    REG_ROW_COUNT      = 3'd1,
    REG_ROW_STEP       = 3'd2,
    REG_START_DELAY    = 3'd3,
    REG_NIBBLE_INTERVAL = 3'd4
  } cfg_idx_e;

  // One queued bus nibble
  typedef struct packed {
    logic       rs;
    logic [3:0] nibble;
  } q_entry_t;

  // One result waiting on the output side
  typedef struct packed {
    logic       rs;
    logic       ovf;
    logic [3:0] nibble;
  } out_entry_t;

  localparam int unsigned QUEUE_DEPTH_DEF = 128;

  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;

  // Reset values of the configuration registers
  localparam logic [5:0]  COLUMN_COUNT_RST    = 6'd16;
  localparam logic [2:0]  ROW_COUNT_RST       = 3'd2;
  localparam logic [6:0]  ROW_STEP_RST        = 7'd64;
  localparam logic [15:0] START_DELAY_RST     = 16'd5;
  localparam logic [15:0] NIBBLE_INTERVAL_RST = 16'd2;

  // Instruction bytes
  localparam logic [7:0] INSTR_CLEAR = 8'h01;

  // Last step of the start-up sequence: one lone nibble plus five bytes
  localparam logic [3:0] INIT_LAST_STEP = 4'd10;

  // Start-up sequence: lone 0x3, then 0x28, 0x08, 0x06, 0x0C, 0x01
  function automatic q_entry_t init_nibble(input logic [3:0] idx);
    q_entry_t e;
    e.rs = 1'b0;
    case (idx)
      4'd0:    e.nibble = 4'h3;
      4'd1:    e.nibble = 4'h2;
      4'd2:    e.nibble = 4'h8;
      4'd3:    e.nibble = 4'h0;
      4'd4:    e.nibble = 4'h8;
      4'd5:    e.nibble = 4'h0;
      4'd6:    e.nibble = 4'h6;
      4'd7:    e.nibble = 4'h0;
      4'd8:    e.nibble = 4'hC;
      4'd9:    e.nibble = 4'h0;
      4'd10:   e.nibble = 4'h1;
      default: e.nibble = 4'h0;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

/* design/clnw_ram.sv */
// ----------------------------------------------------------------------------
// clnw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module clnw_ram #(
  parameter int unsigned WIDTH = 5,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* design/char_lcd_nibble_writer_unit.sv */
// A tick that pops a nibble shows its result on the output after the FIFO read
//   register and then the output buffer.
// Throughput: 1 command per cycle while the sequencer is idle or on its last nibble and
//   the two-entry output buffer plus any read in flight hold fewer than two results;
//   clear and set cursor queue 2 nibbles, write char 2 or 4, initialize 11, one per busy cycle.
// Reset: control state cleared at once; FIFO contents undefined, no clear pass.
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_unit
// Character-LCD front end for a 4-bit bus: commands become tagged nibbles in a
// FIFO memory, paced out one per nibble interval of ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_writer_unit #(
  parameter int unsigned QUEUE_DEPTH = clnw_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // input commands
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [15:0]                 s_axis_tdata,  // char_code[7:0], column[13:8], row[15:14]
  input  wire logic [2:0]                  s_axis_tuser,  // cmd[2:0]
  // output nibbles
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [7:0]                       m_axis_tdata,  // bus_nibble[3:0], overflowed[4], zero[7:5]
  output logic [0:0]                       m_axis_tuser,  // reg_select[0]
  // configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [clnw_pkg::CFG_AW-1:0] paddr,
  input  wire logic [clnw_pkg::CFG_DW-1:0] pwdata,
  output logic      [clnw_pkg::CFG_DW-1:0] prdata,
  output logic                             pready
);

  import clnw_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // configuration registers
  logic [5:0]  column_count_q;
  logic [2:0]  row_count_q;
  logic [6:0]  row_step_q;
  logic [15:0] start_delay_q;
  logic [15:0] interval_q;

  logic     cfg_wr;
  cfg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = cfg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q <= COLUMN_COUNT_RST;
      row_count_q    <= ROW_COUNT_RST;
      row_step_q     <= ROW_STEP_RST;
      start_delay_q  <= START_DELAY_RST;
      interval_q     <= NIBBLE_INTERVAL_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_COLUMN_COUNT:    column_count_q <= pwdata[5:0];
        REG_ROW_COUNT:       row_count_q    <= pwdata[2:0];
        REG_ROW_STEP:        row_step_q     <= pwdata[6:0];
        REG_START_DELAY:     start_delay_q  <= pwdata[15:0];
        REG_NIBBLE_INTERVAL: interval_q     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      REG_COLUMN_COUNT:    prdata = {26'd0, column_count_q};
      REG_ROW_COUNT:       prdata = {29'd0, row_count_q};
      REG_ROW_STEP:        prdata = {25'd0, row_step_q};
      REG_START_DELAY:     prdata = {16'd0, start_delay_q};
      REG_NIBBLE_INTERVAL: prdata = {16'd0, interval_q};
      default:             prdata = '0;
    endcase
  end

  // input fields
  cmd_e       cmd;
  logic [7:0] in_char;
  logic [5:0] in_col;
  logic [1:0] in_row;
  logic       s_xfer;

  assign cmd     = cmd_e'(s_axis_tuser);
  assign in_char = s_axis_tdata[7:0];
  assign in_col  = s_axis_tdata[13:8];
  assign in_row  = s_axis_tdata[15:14];

  // state
  logic [5:0]    cur_col_q, cur_col_d;
  logic [1:0]    cur_row_q, cur_row_d;
  logic [15:0]   countdown_q, countdown_d;
  logic          pacing_q, pacing_d;
  logic          ovf_q;
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  // nibble sequencer: emits one FIFO write per busy cycle, dropping the nibble while the FIFO is full
  logic          busy_q, busy_d;
  logic          init_job_q, init_job_d;
  logic [3:0]    step_q, step_d;
  logic [3:0]    last_q, last_d;
  q_entry_t      nib_q [4];
  q_entry_t      nib_d [4];

  logic          last_cycle;
  q_entry_t      push_data;
  logic          push_ok;
  logic          drop;
  logic          pop;

  // output buffer (two entries) and read in flight
  out_entry_t    out_q [2];
  logic          out_wr_q, out_rd_q;
  logic [1:0]    out_cnt_q;
  logic          rd_pend_q;
  logic          ovf_pend_q;
  logic          fwd_q;
  q_entry_t      fwd_data_q;
  q_entry_t      ram_rdata;
  q_entry_t      rd_entry;
  logic [2:0]    credit_used;
  logic          out_pop;

  assign last_cycle  = busy_q && (step_q == last_q);
  assign credit_used = {1'b0, out_cnt_q} + {2'b00, rd_pend_q};
  assign s_axis_tready = (!busy_q || last_cycle) && (credit_used < 3'd2);
  assign s_xfer      = s_axis_tvalid & s_axis_tready;

  // FIFO write side
  assign push_data = init_job_q ? init_nibble(step_q) : nib_q[step_q[1:0]];
  assign push_ok   = busy_q && (count_q < CW'(QUEUE_DEPTH));
  assign drop      = busy_q && !push_ok;

  // command decode
  logic [2:0] row_inc;
  logic [1:0] wrap_row;
  logic       wrap;
  logic [8:0] wrap_prod;
  logic [8:0] set_prod;
  logic [6:0] set_addr;

  always_comb begin
    row_inc   = {1'b0, cur_row_q} + 3'd1;
    wrap_row  = (row_inc >= row_count_q) ? 2'd0 : row_inc[1:0];
    wrap      = cur_col_q >= column_count_q;
    wrap_prod = 9'(wrap_row) * 9'(row_step_q);
    set_prod  = 9'(in_row) * 9'(row_step_q);
    set_addr  = set_prod[6:0] + {1'b0, in_col};
  end

  always_comb begin
    busy_d      = busy_q && !last_cycle;
    step_d      = busy_q ? step_q + 4'd1 : step_q;
    last_d      = last_q;
    init_job_d  = init_job_q;
    nib_d       = nib_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    countdown_d = countdown_q;
    pacing_d    = pacing_q;
    pop         = 1'b0;
    if (s_xfer) begin
      case (cmd)
        CMD_TICK: begin
          if (pacing_q) begin
            if (countdown_q > 16'd1) begin
              countdown_d = countdown_q - 16'd1;
            end else begin
              countdown_d = interval_q;
              pop         = (count_q != '0) || push_ok;
            end
          end
        end
        CMD_WRITE: begin
          busy_d     = 1'b1;
          step_d     = 4'd0;
          init_job_d = 1'b0;
          if (wrap) begin
            nib_d[0]  = '{rs: 1'b0, nibble: {1'b1, wrap_prod[6:4]}};
            nib_d[1]  = '{rs: 1'b0, nibble: wrap_prod[3:0]};
            nib_d[2]  = '{rs: 1'b1, nibble: in_char[7:4]};
            nib_d[3]  = '{rs: 1'b1, nibble: in_char[3:0]};
            last_d    = 4'd3;
            cur_row_d = wrap_row;
            cur_col_d = 6'd1;
          end else begin
            nib_d[0]  = '{rs: 1'b1, nibble: in_char[7:4]};
            nib_d[1]  = '{rs: 1'b1, nibble: in_char[3:0]};
            last_d    = 4'd1;
            cur_col_d = cur_col_q + 6'd1;
          end
        end
        CMD_SETPOS: begin
          busy_d     = 1'b1;
          step_d     = 4'd0;
          init_job_d = 1'b0;
          nib_d[0]   = '{rs: 1'b0, nibble: {1'b1, set_addr[6:4]}};
          nib_d[1]   = '{rs: 1'b0, nibble: set_addr[3:0]};
          last_d     = 4'd1;
          cur_col_d  = in_col;
          cur_row_d  = in_row;
        end
        CMD_CLEAR: begin
          busy_d     = 1'b1;
          step_d     = 4'd0;
          init_job_d = 1'b0;
          nib_d[0]   = '{rs: 1'b0, nibble: INSTR_CLEAR[7:4]};
          nib_d[1]   = '{rs: 1'b0, nibble: INSTR_CLEAR[3:0]};
          last_d     = 4'd1;
        end
        CMD_INIT: begin
          busy_d      = 1'b1;
          step_d      = 4'd0;
          init_job_d  = 1'b1;
          last_d      = INIT_LAST_STEP;
          countdown_d = start_delay_q;
          pacing_d    = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      init_job_q  <= 1'b0;
      step_q      <= '0;
      last_q      <= '0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      countdown_q <= START_DELAY_RST;
      pacing_q    <= 1'b0;
      ovf_q       <= 1'b0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      count_q     <= '0;
      rd_pend_q   <= 1'b0;
      fwd_q       <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      init_job_q  <= init_job_d;
      step_q      <= step_d;
      last_q      <= last_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      countdown_q <= countdown_d;
      pacing_q    <= pacing_d;
      ovf_q       <= ovf_q | drop;
      if (push_ok) begin
        wr_ptr_q <= (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      count_q   <= count_q + CW'(push_ok) - CW'(pop);
      rd_pend_q <= pop;
      // an empty FIFO written and read in the same cycle: bypass the RAM
      fwd_q     <= pop && push_ok && (count_q == '0);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    nib_q      <= nib_d;
    fwd_data_q <= push_data;
    ovf_pend_q <= ovf_q | drop;
  end

  // nibble FIFO storage
  clnw_ram #(
    .WIDTH ($bits(q_entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (push_ok),
    .waddr_i (wr_ptr_q),
    .wdata_i (push_data),
    .re_i    (pop),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  assign rd_entry = fwd_q ? fwd_data_q : ram_rdata;

  // output buffer
  assign out_pop = m_axis_tvalid & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wr_q  <= 1'b0;
      out_rd_q  <= 1'b0;
      out_cnt_q <= '0;
    end else begin
      if (rd_pend_q) begin
        out_wr_q <= ~out_wr_q;
      end
      if (out_pop) begin
        out_rd_q <= ~out_rd_q;
      end
      out_cnt_q <= out_cnt_q + 2'(rd_pend_q) - 2'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_pend_q) begin
      out_q[out_wr_q] <= '{rs: rd_entry.rs, ovf: ovf_pend_q, nibble: rd_entry.nibble};
    end
  end

  assign m_axis_tvalid = out_cnt_q != '0;
  assign m_axis_tdata  = {3'b000, out_q[out_rd_q].ovf, out_q[out_rd_q].nibble};
  assign m_axis_tuser  = out_q[out_rd_q].rs;

endmodule

`default_nettype wire

/* design/clnw_checker.sv */
// ----------------------------------------------------------------------------
// clnw_checker
// Port-level checks of the character-LCD nibble writer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module clnw_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [2:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser
);

  import clnw_pkg::*;

  logic seen_ovf_q;

  // remember that a result reported a dropped nibble
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_ovf_q <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready && m_axis_tdata[4]) begin
      seen_ovf_q <= 1'b1;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output changed while stalled");

  // a fresh result follows a tick transfer
  a_out_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |->
      $past(s_axis_tvalid && s_axis_tready, 2) && ($past(s_axis_tuser, 2) == CMD_TICK))
    else $error("result without a tick");

  // overflow flag is sticky across results
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && seen_ovf_q |-> m_axis_tdata[4])
    else $error("overflow flag cleared");

  // pad bits of the result stay zero
  a_out_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:5] == 3'b000))
    else $error("nonzero pad bits");

endmodule

bind char_lcd_nibble_writer_unit clnw_checker u_clnw_checker (.*);

`default_nettype wire
